// ----- src/tlne_pkg.sv -----
// Shared types, character codes and sizes for the text line numbering and escape block.
package tlne_pkg;

  // Sizes
  localparam int COUNT_DIGITS = 10;
  localparam int MAX_RESULTS  = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int TAIL_MAX     = 4;
  localparam int DIG_W        = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
  localparam int CNT_W        = $clog2(MAX_RESULTS);
  localparam int TAIL_W       = $clog2(TAIL_MAX);

  // Numbering modes
  localparam logic [1:0] NUM_NONE     = 2'd0;
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;
  localparam logic [1:0] NUM_SPARE    = 2'd3;

  // Option register indexes; byte address is four times the index
  typedef enum logic [2:0] {
    REG_NUMBER_MODE   = 3'd0,
    REG_SQUEEZE_BLANK = 3'd1,
    REG_SHOW_ENDS     = 3'd2,
    REG_SHOW_TABS     = 3'd3,
    REG_SHOW_NONPRINT = 3'd4
  } cfg_reg_t;

  // Character codes
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_CTRL_TOP = 8'h20;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [COUNT_DIGITS-1:0] counter_t;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprint;
  } cfg_t;

  // One classified item: optional line number, then one to four tail bytes
  typedef struct packed {
    logic                        num_en;
    counter_t                    digits;
    logic [TAIL_MAX-1:0][7:0]    tail;
    logic [TAIL_W-1:0]           tail_last;
  } job_t;

  typedef struct packed {
    logic             busy;
    logic             emit;
    logic             last_byte;
    logic [CNT_W-1:0] cnt;
  } bk_status_t;

endpackage

// ----- src/text_line_number_escape.sv -----
// Top level of the text line numbering and escape block.
//
// Input channel: data_byte and file_start with in_valid / in_ready. Each item
// is one text byte; file_start on an item clears the line counter and line
// state before that byte is handled. Output channel: out_byte and last_of_run
// with out_valid / out_ready; last_of_run marks the final byte of an item.
// An item yields up to sixteen bytes; a squeezed blank line yields none.
// Options are set through the APB port (number_mode, squeeze_blank, show_ends,
// show_tabs, show_nonprint at byte addresses 0, 4, 8, 12, 16); the user must
// change them only while the block is idle, as the block does not enforce it.
// Path: with the back part idle, the first byte of an item goes through the
// queue write, the load into the sequencer and the output register.
// Throughput: one output byte per cycle while out_ready does not stall it,
// set by the back sequencer, which takes the next job on the final byte of
// the current one, so plain text runs at one item a cycle.
// A two-entry job queue lets the front keep accepting while the receiver
// stalls; when both entries fill, in_ready drops until a job is taken.
// Reset clears the counter to zero, sets line start, drops pending output
// and returns all options to zero.
module text_line_number_escape (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        out_valid,
  input  logic        out_ready
);

  tlne_pkg::cfg_t        cfg;
  tlne_pkg::job_t        push_job;
  tlne_pkg::job_t        q_job;
  tlne_pkg::bk_status_t  bk_status;
  logic                  push_valid;
  logic                  push_ready;
  logic                  q_valid;
  logic                  q_ready;
  logic                  cfg_wr;
  logic [2:0]            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Option registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tlne_pkg::REG_NUMBER_MODE:   cfg.number_mode   <= pwdata[1:0];
        tlne_pkg::REG_SQUEEZE_BLANK: cfg.squeeze_blank <= pwdata[0];
        tlne_pkg::REG_SHOW_ENDS:     cfg.show_ends     <= pwdata[0];
        tlne_pkg::REG_SHOW_TABS:     cfg.show_tabs     <= pwdata[0];
        tlne_pkg::REG_SHOW_NONPRINT: cfg.show_nonprint <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      tlne_pkg::REG_NUMBER_MODE:   prdata = {30'd0, cfg.number_mode};
      tlne_pkg::REG_SQUEEZE_BLANK: prdata = {31'd0, cfg.squeeze_blank};
      tlne_pkg::REG_SHOW_ENDS:     prdata = {31'd0, cfg.show_ends};
      tlne_pkg::REG_SHOW_TABS:     prdata = {31'd0, cfg.show_tabs};
      tlne_pkg::REG_SHOW_NONPRINT: prdata = {31'd0, cfg.show_nonprint};
      default:                     prdata = '0;
    endcase
  end

  tlne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .data_byte  (data_byte),
    .file_start (file_start),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  tlne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_job   (push_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_job   (q_job)
  );

  tlne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_job       (q_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .status      (bk_status)
  );

  // A new job is taken only when the sequencer is idle or on its final byte
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |-> !bk_status.busy || (bk_status.emit && bk_status.last_byte))
    else $error("job loaded while sequencer mid-item");

  // The sixteenth byte of an item always closes the run
  a_cap_closes_run: assert property (@(posedge clk) disable iff (rst)
    bk_status.emit && bk_status.cnt == tlne_pkg::CNT_W'(tlne_pkg::MAX_RESULTS - 1)
    |=> out_valid && last_of_run)
    else $error("byte limit reached without last_of_run");

  // After the final byte is emitted the sequencer is idle unless a job was loaded
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    bk_status.emit && bk_status.last_byte && !q_valid |=> !bk_status.busy)
    else $error("sequencer still busy after final byte");

  // Nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ----- src/tlne_front.sv -----
// Front part: accepts input items, tracks line state and the BCD counter, builds jobs.
module tlne_front (
  input  logic              clk,
  input  logic              rst,
  input  tlne_pkg::cfg_t    cfg,
  input  logic [7:0]        data_byte,
  input  logic              file_start,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              push_valid,
  input  logic              push_ready,
  output tlne_pkg::job_t    push_job
);

  tlne_pkg::counter_t line_counter;
  logic               line_start;
  logic               previous_blank;

  tlne_pkg::counter_t line_counter_next;
  logic               line_start_next;
  logic               previous_blank_next;

  tlne_pkg::counter_t lc;
  tlne_pkg::counter_t lc_inc;
  logic               als;
  logic               pb;
  logic               blank;
  logic               squeezed;
  logic               num_en;
  logic               full;
  logic               carry;
  logic               accept;
  logic [7:0]         low;
  logic [7:0]         esc0;
  logic [7:0]         esc1;
  logic               esc_two;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Saturating BCD increment
  always_comb begin
    full   = 1'b1;
    carry  = 1'b1;
    lc_inc = lc;
    for (int i = 0; i < tlne_pkg::COUNT_DIGITS; i++) begin
      if (lc[i] != 4'd9) full = 1'b0;
    end
    for (int i = 0; i < tlne_pkg::COUNT_DIGITS; i++) begin
      if (carry) lc_inc[i] = (lc[i] >= 4'd9) ? 4'd0 : lc[i] + 4'd1;
      carry = carry && (lc[i] >= 4'd9);
    end
    if (full) lc_inc = lc;
  end

  // Line state and numbering decision
  always_comb begin
    lc       = file_start ? '0 : line_counter;
    als      = file_start ? 1'b1 : line_start;
    pb       = file_start ? 1'b0 : previous_blank;
    blank    = (data_byte == tlne_pkg::CH_NL);
    squeezed = als && cfg.squeeze_blank && blank && pb;
    num_en   = als && !squeezed &&
               ((cfg.number_mode == tlne_pkg::NUM_ALL) ||
                (cfg.number_mode == tlne_pkg::NUM_NONBLANK && !blank));

    line_counter_next   = num_en ? lc_inc : lc;
    previous_blank_next = (als && !squeezed) ? blank : pb;
    line_start_next     = squeezed ? 1'b1 : blank;
  end

  // Caret escape of the low seven bits, used after M- for high bytes
  always_comb begin
    low     = {1'b0, data_byte[6:0]};
    esc0    = low;
    esc1    = '0;
    esc_two = 1'b0;
    if (low < tlne_pkg::CH_CTRL_TOP) begin
      esc0    = tlne_pkg::CH_CARET;
      esc1    = low + tlne_pkg::CTRL_OFFSET;
      esc_two = 1'b1;
    end else if (low == tlne_pkg::CH_DEL) begin
      esc0    = tlne_pkg::CH_CARET;
      esc1    = tlne_pkg::CH_QMARK;
      esc_two = 1'b1;
    end
  end

  // Job fields: number flag, digits and tail bytes
  always_comb begin
    push_job           = '0;
    push_job.num_en    = num_en;
    push_job.digits    = line_counter_next;
    push_job.tail[0]   = data_byte;
    if (data_byte == tlne_pkg::CH_NL) begin
      if (cfg.show_ends) begin
        push_job.tail[0]   = tlne_pkg::CH_DOLLAR;
        push_job.tail[1]   = tlne_pkg::CH_NL;
        push_job.tail_last = tlne_pkg::TAIL_W'(1);
      end
    end else if (data_byte == tlne_pkg::CH_TAB) begin
      if (cfg.show_tabs) begin
        push_job.tail[0]   = tlne_pkg::CH_CARET;
        push_job.tail[1]   = tlne_pkg::CH_I;
        push_job.tail_last = tlne_pkg::TAIL_W'(1);
      end
    end else if (cfg.show_nonprint) begin
      if (data_byte[7]) begin
        push_job.tail[0]   = tlne_pkg::CH_M;
        push_job.tail[1]   = tlne_pkg::CH_DASH;
        push_job.tail[2]   = esc0;
        push_job.tail[3]   = esc1;
        push_job.tail_last = esc_two ? tlne_pkg::TAIL_W'(3) : tlne_pkg::TAIL_W'(2);
      end else begin
        push_job.tail[0]   = esc0;
        push_job.tail[1]   = esc1;
        push_job.tail_last = esc_two ? tlne_pkg::TAIL_W'(1) : tlne_pkg::TAIL_W'(0);
      end
    end
  end

  // A squeezed line start yields nothing
  assign push_valid = in_valid && !squeezed;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_counter   <= '0;
      line_start     <= 1'b1;
      previous_blank <= 1'b0;
    end else if (accept) begin
      line_counter   <= line_counter_next;
      line_start     <= line_start_next;
      previous_blank <= previous_blank_next;
    end
  end

endmodule

// ----- src/tlne_queue.sv -----
// Short job queue between the front and back parts.
module tlne_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  tlne_pkg::job_t  wr_job,
  output logic            rd_valid,
  input  logic            rd_ready,
  output tlne_pkg::job_t  rd_job
);

  localparam int PTR_W = (tlne_pkg::QUEUE_DEPTH > 1) ? $clog2(tlne_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(tlne_pkg::QUEUE_DEPTH + 1);

  tlne_pkg::job_t    entries [tlne_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill != FILL_W'(tlne_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_job   = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_job;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(tlne_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(tlne_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- src/tlne_back.sv -----
// Back part: byte sequencer that spells out the line number and tail of each job.
module tlne_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  tlne_pkg::job_t        q_job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  last_of_run,
  output tlne_pkg::bk_status_t  status
);

  localparam logic [1:0] PH_DIGIT = 2'd0;
  localparam logic [1:0] PH_SP1   = 2'd1;
  localparam logic [1:0] PH_SP2   = 2'd2;
  localparam logic [1:0] PH_TAIL  = 2'd3;

  tlne_pkg::job_t                job;
  logic                          busy;
  logic [1:0]                    phase;
  logic [tlne_pkg::DIG_W-1:0]    d_idx;
  logic [tlne_pkg::TAIL_W-1:0]   t_idx;
  logic [tlne_pkg::CNT_W-1:0]    cnt;

  logic [tlne_pkg::DIG_W-1:0]    top;
  logic [7:0]                    cur_byte;
  tlne_pkg::bcd_t                dv;
  logic                          emit;
  logic                          last_byte;
  logic                          load;

  // Most significant nonzero digit of the incoming job
  always_comb begin
    top = '0;
    for (int i = 0; i < tlne_pkg::COUNT_DIGITS; i++) begin
      if (q_job.digits[i] != 4'd0) top = tlne_pkg::DIG_W'(i);
    end
  end

  // Byte for the current position
  always_comb begin
    dv       = job.digits[d_idx];
    cur_byte = '0;
    unique case (phase) inside
      PH_DIGIT: cur_byte = tlne_pkg::CH_ZERO + {4'd0, (dv > 4'd9) ? 4'd9 : dv};
      PH_SP1, PH_SP2: cur_byte = tlne_pkg::CH_SPACE;
      PH_TAIL:  cur_byte = job.tail[t_idx];
      default:  cur_byte = '0;
    endcase
  end

  assign emit      = busy && (!out_valid || out_ready);
  assign last_byte = (phase == PH_TAIL && t_idx == job.tail_last) ||
                     (cnt == tlne_pkg::CNT_W'(tlne_pkg::MAX_RESULTS - 1));
  assign q_ready   = !busy || (emit && last_byte);
  assign load      = q_valid && q_ready;

  assign status.busy      = busy;
  assign status.emit      = emit;
  assign status.last_byte = last_byte;
  assign status.cnt       = cnt;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) busy <= 1'b1;
      else if (emit && last_byte) busy <= 1'b0;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Sequencer position and output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= cur_byte;
      last_of_run <= last_byte;
    end
    if (load) begin
      job   <= q_job;
      cnt   <= '0;
      phase <= q_job.num_en ? PH_DIGIT : PH_TAIL;
      d_idx <= top;
      t_idx <= '0;
    end else if (emit) begin
      cnt <= cnt + 1'b1;
      unique case (phase)
        PH_DIGIT: begin
          if (d_idx == '0) phase <= PH_SP1;
          else d_idx <= d_idx - 1'b1;
        end
        PH_SP1: phase <= PH_SP2;
        PH_SP2: begin
          phase <= PH_TAIL;
          t_idx <= '0;
        end
        PH_TAIL: t_idx <= t_idx + 1'b1;
        default: phase <= PH_TAIL;
      endcase
    end
  end

endmodule

// ----- tb/sv/text_line_number_escape_test.sv -----
// Self-checking testbench for the text line numbering and escape block.
`timescale 1ns / 100ps

module text_line_number_escape_test;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  // One row of the directed plan: an option write or an input item
  typedef struct packed {
    logic               is_cfg;
    tlne_pkg::cfg_reg_t reg_idx;
    logic [31:0]        value;
    logic [7:0]         data;
    logic               fs;
    logic               typed;
    logic [3:0]         nexp;
    logic [47:0]        text;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [7:0]  data_byte = '0;
  logic        file_start = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        out_valid;
  logic        out_ready = 1'b0;

  text_line_number_escape i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .data_byte   (data_byte),
    .file_start  (file_start),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  // Clock, 4 ns period
  initial begin
    forever #2 clk = ~clk;
  end

  // Options as the block should hold them
  logic [1:0] exp_num_mode;
  logic       exp_squeeze;
  logic       exp_show_ends;
  logic       exp_show_tabs;
  logic       exp_escape;

  // Line state of the text model
  tlne_pkg::counter_t line_count;
  logic               at_bol;
  logic               last_line_blank;

  logic [7:0] run_buf[$];
  out_char_t  text_due[$];
  plan_row_t  plan[$];

  int errors = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int settings_used = 0;
  int burst_left = 0;

  // Mismatch report: one line, counted
  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Text model
  // ---------------------------------------------------------------------------

  function automatic void put_char(logic [7:0] c);
    if (run_buf.size() < tlne_pkg::MAX_RESULTS) run_buf.push_back(c);
  endfunction

  // BCD increment, held at all nines
  function automatic void bump_count();
    logic full;
    logic carry;
    full = 1'b1;
    for (int i = 0; i < tlne_pkg::COUNT_DIGITS; i++)
      if (line_count[i] != 4'd9) full = 1'b0;
    if (!full) begin
      carry = 1'b1;
      for (int i = 0; i < tlne_pkg::COUNT_DIGITS; i++) begin
        if (carry) begin
          if (line_count[i] >= 4'd9) begin
            line_count[i] = 4'd0;
          end else begin
            line_count[i] = line_count[i] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  endfunction

  // Line number without leading zeros, then two spaces
  function automatic void put_number();
    int             top;
    logic           found;
    tlne_pkg::bcd_t d;
    top = 0;
    found = 1'b0;
    for (int i = tlne_pkg::COUNT_DIGITS - 1; i >= 0; i--) begin
      if (!found && line_count[i] != 4'd0) begin
        top = i;
        found = 1'b1;
      end
    end
    for (int i = top; i >= 0; i--) begin
      d = line_count[i];
      put_char(tlne_pkg::CH_ZERO + ((d > 4'd9) ? 8'd9 : {4'd0, d}));
    end
    put_char(tlne_pkg::CH_SPACE);
    put_char(tlne_pkg::CH_SPACE);
  endfunction

  // Bytes that one input item turns into, left in run_buf
  function automatic void render_byte(logic [7:0] b, logic fs);
    logic       blank;
    logic [7:0] low;
    run_buf.delete();
    if (fs) begin
      line_count = '0;
      at_bol = 1'b1;
      last_line_blank = 1'b0;
    end
    blank = (b == tlne_pkg::CH_NL);
    if (at_bol) begin
      // repeated blank line dropped whole
      if (exp_squeeze && blank && last_line_blank) return;
      last_line_blank = blank;
      if (exp_num_mode == tlne_pkg::NUM_ALL ||
          (exp_num_mode == tlne_pkg::NUM_NONBLANK && !blank)) begin
        bump_count();
        put_number();
      end
      at_bol = 1'b0;
    end
    if (b == tlne_pkg::CH_NL) begin
      if (exp_show_ends) put_char(tlne_pkg::CH_DOLLAR);
      put_char(tlne_pkg::CH_NL);
      at_bol = 1'b1;
    end else if (b == tlne_pkg::CH_TAB) begin
      if (exp_show_tabs) begin
        put_char(tlne_pkg::CH_CARET);
        put_char(tlne_pkg::CH_I);
      end else begin
        put_char(tlne_pkg::CH_TAB);
      end
    end else if (exp_escape) begin
      low = b;
      if (b[7]) begin
        put_char(tlne_pkg::CH_M);
        put_char(tlne_pkg::CH_DASH);
        low = {1'b0, b[6:0]};
      end
      if (low < tlne_pkg::CH_CTRL_TOP) begin
        put_char(tlne_pkg::CH_CARET);
        put_char(low + tlne_pkg::CTRL_OFFSET);
      end else if (low == tlne_pkg::CH_DEL) begin
        put_char(tlne_pkg::CH_CARET);
        put_char(tlne_pkg::CH_QMARK);
      end else begin
        put_char(low);
      end
    end else begin
      put_char(b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // APB write: setup then access; the model follows at the write edge
  task automatic cfg_write(tlne_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tlne_pkg::REG_NUMBER_MODE:   exp_num_mode  = val[1:0];
      tlne_pkg::REG_SQUEEZE_BLANK: exp_squeeze   = val[0];
      tlne_pkg::REG_SHOW_ENDS:     exp_show_ends = val[0];
      tlne_pkg::REG_SHOW_TABS:     exp_show_tabs = val[0];
      tlne_pkg::REG_SHOW_NONPRINT: exp_escape    = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_options(logic [1:0] nm, logic sq, logic se, logic st, logic sn);
    cfg_write(tlne_pkg::REG_NUMBER_MODE, {30'd0, nm});
    cfg_write(tlne_pkg::REG_SQUEEZE_BLANK, {31'd0, sq});
    cfg_write(tlne_pkg::REG_SHOW_ENDS, {31'd0, se});
    cfg_write(tlne_pkg::REG_SHOW_TABS, {31'd0, st});
    cfg_write(tlne_pkg::REG_SHOW_NONPRINT, {31'd0, sn});
    settings_used++;
  endtask

  // Present one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(logic [7:0] b, logic fs, logic typed, logic [3:0] nexp,
                           logic [47:0] text);
    @(negedge clk);
    in_valid   <= 1'b1;
    data_byte  <= b;
    file_start <= fs;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    render_byte(b, fs);
    if (typed) begin
      for (int k = 0; k < nexp; k++)
        text_due.push_back('{ch: text[8*(nexp-1-k) +: 8], last: (k == nexp - 1)});
    end else begin
      foreach (run_buf[k])
        text_due.push_back('{ch: run_buf[k], last: (k == run_buf.size() - 1)});
    end
  endtask

  task automatic pause(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Sender bursts: random burst length, then a random gap or none
  task automatic maybe_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
    end
  endtask

  // Wait until every expected byte is out, then let the block settle
  task automatic drain();
    pause(1);
    while (text_due.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Mostly text with lines, some tabs, controls and high bytes
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)      return tlne_pkg::CH_NL;
    else if (r < 20) return tlne_pkg::CH_TAB;
    else if (r < 32) return 8'($urandom_range(0, 255));
    else if (r < 37) return 8'($urandom_range(0, 31));
    else if (r < 44) return 8'($urandom_range(128, 255));
    else if (r < 46) return tlne_pkg::CH_DEL;
    else             return 8'($urandom_range(32, 126));
  endfunction

  task automatic plan_cfg(tlne_pkg::cfg_reg_t idx, logic [31:0] val);
    plan.push_back('{is_cfg: 1'b1, reg_idx: idx, value: val, data: '0, fs: 1'b0,
                     typed: 1'b0, nexp: '0, text: '0});
  endtask

  task automatic plan_byte(logic [7:0] b, logic fs, logic typed, logic [3:0] nexp,
                           logic [47:0] text);
    plan.push_back('{is_cfg: 1'b0, reg_idx: tlne_pkg::REG_NUMBER_MODE, value: '0,
                     data: b, fs: fs, typed: typed, nexp: nexp, text: text});
  endtask

  // Receiver: stall pattern of its own, picked anew for every segment
  initial begin
    int mode;
    int seg;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 60);
      for (int c = 0; c < seg; c++) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ((c % 5) == 4);
          default: out_ready <= ((c % 8) < 3);
        endcase
      end
    end
  end

  // Output checker: every accepted byte against the oldest expectation
  always @(posedge clk) begin : check_out
    out_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (text_due.size() == 0) begin
        report_mismatch("output byte with nothing expected", out_byte, 0);
      end else begin
        want = text_due.pop_front();
        bytes_checked++;
        if (out_byte !== want.ch) report_mismatch("out_byte", out_byte, want.ch);
        if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    exp_num_mode    = tlne_pkg::NUM_NONE;
    exp_squeeze     = 1'b0;
    exp_show_ends   = 1'b0;
    exp_show_tabs   = 1'b0;
    exp_escape      = 1'b0;
    line_count      = '0;
    at_bol          = 1'b1;
    last_line_blank = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed plan: plain after reset, escapes, tabs, ends, numbering, squeeze
    plan_byte("A", 1'b1, 1'b1, 1, "A");
    plan_byte(8'h00, 1'b0, 1'b1, 1, 48'h00);
    plan_byte(8'hFF, 1'b0, 1'b1, 1, 48'hFF);
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b1, 1, "\n");
    plan_cfg(tlne_pkg::REG_SHOW_NONPRINT, 32'd1);
    plan_cfg(tlne_pkg::REG_SHOW_TABS, 32'd1);
    plan_cfg(tlne_pkg::REG_SHOW_ENDS, 32'd1);
    plan_byte(8'h01, 1'b0, 1'b1, 2, "^A");
    plan_byte(tlne_pkg::CH_DEL, 1'b0, 1'b1, 2, "^?");
    plan_byte(8'h80, 1'b0, 1'b1, 4, "M-^@");
    plan_byte(8'hFF, 1'b0, 1'b1, 4, "M-^?");
    plan_byte(8'hA0, 1'b0, 1'b1, 3, "M- ");
    plan_byte(tlne_pkg::CH_TAB, 1'b0, 1'b1, 2, "^I");
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b1, 2, "$\n");
    // tab passes through with escaping on
    plan_cfg(tlne_pkg::REG_SHOW_TABS, 32'd0);
    plan_byte(tlne_pkg::CH_TAB, 1'b0, 1'b1, 1, 48'h09);
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b1, 2, "$\n");
    plan_cfg(tlne_pkg::REG_NUMBER_MODE, {30'd0, tlne_pkg::NUM_ALL});
    plan_cfg(tlne_pkg::REG_SQUEEZE_BLANK, 32'd1);
    plan_cfg(tlne_pkg::REG_SHOW_ENDS, 32'd0);
    plan_byte("a", 1'b1, 1'b1, 4, "1  a");
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b1, 1, "\n");
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b1, 4, "2  \n");
    // second blank line in a row is squeezed out
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b1, 0, '0);
    plan_byte("b", 1'b0, 1'b1, 4, "3  b");
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b0, 0, '0);
    // nonblank numbering, counter cleared by the file start
    plan_cfg(tlne_pkg::REG_NUMBER_MODE, {30'd0, tlne_pkg::NUM_NONBLANK});
    plan_byte(tlne_pkg::CH_NL, 1'b1, 1'b1, 1, "\n");
    plan_byte("c", 1'b0, 1'b1, 4, "1  c");
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b0, 0, '0);
    // unused mode numbers nothing
    plan_cfg(tlne_pkg::REG_NUMBER_MODE, {30'd0, tlne_pkg::NUM_SPARE});
    plan_byte("d", 1'b0, 1'b1, 1, "d");
    plan_byte(tlne_pkg::CH_NL, 1'b0, 1'b0, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        cfg_write(plan[i].reg_idx, plan[i].value);
      end else begin
        send_item(plan[i].data, plan[i].fs, plan[i].typed, plan[i].nexp, plan[i].text);
        maybe_gap();
      end
    end
    settings_used += 5;

    // Random phases: four fixed settings first, then random settings
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_options(tlne_pkg::NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
        1: set_options(tlne_pkg::NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
        2: set_options(tlne_pkg::NUM_NONBLANK, 1'b1, 1'b0, 1'b1, 1'b0);
        3: set_options(tlne_pkg::NUM_SPARE, 1'b0, 1'b1, 1'b0, 1'b1);
        default: set_options(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
      endcase
      for (int k = 0; k < 31; k++) begin
        send_item(pick_text_byte(), ($urandom_range(0, 29) == 0), 1'b0, 0, '0);
        maybe_gap();
        // hold the sender until the block has emptied
        if (ph == 2 && k == 17) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (text_due.size() != 0)
      report_mismatch("expected bytes never produced", 0, text_due.size());

    $display("Run covered %0d input items under %0d option settings, %0d output bytes checked",
             items_sent, settings_used, bytes_checked);
    $display("Numbering modes, blank squeezing, end and tab marks and byte escapes exercised");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
